// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the drive enable sequencer.
// Every macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/des_pkg.sv =====
// Package for the drive enable sequencer: field widths, codes, item types and
// status word decode helpers. Has no dependencies.
package des_pkg;

   localparam int POSITION_BITS = 32;

   localparam int STATUS_W = 16;
   localparam int DATA_W   = 32;
   localparam int CW_W     = 8;
   localparam int ERR_W    = 3;
   localparam int MODE_W   = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   localparam logic [DATA_W-1:0] POS_MASK = (POSITION_BITS >= DATA_W) ? {DATA_W{1'b1}} :
      DATA_W'((64'd1 << POSITION_BITS) - 64'd1);

   localparam logic OP_POWER     = 1'b0;
   localparam logic OP_RESET_ERR = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELDBUS_READY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OP_MODE        = 1'b1;

   localparam logic OPMODE_POSITION = 1'b0;

   localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
   localparam logic [ERR_W-1:0] ERR_FIELDBUS    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_POWER_ON    = 3'd2;
   localparam logic [ERR_W-1:0] ERR_POWERED_ON  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_POWER_OFF   = 3'd4;

   localparam logic [CW_W-1:0] CW_DISABLE_VOLTAGE = 8'h00;
   localparam logic [CW_W-1:0] CW_FAULT_RESET     = 8'h80;
   localparam logic [CW_W-1:0] CW_SHUTDOWN        = 8'h06;
   localparam logic [CW_W-1:0] CW_SWITCH_ON       = 8'h07;
   localparam logic [CW_W-1:0] CW_ENABLE_OP       = 8'h0F;

   localparam logic [MODE_W-1:0] MODE_NONE     = 8'd0;
   localparam logic [MODE_W-1:0] MODE_POSITION = 8'd8;
   localparam logic [MODE_W-1:0] MODE_VELOCITY = 8'd9;

   localparam logic [STATUS_W-1:0] SW_MASK_STATE  = 16'h004F;
   localparam logic [STATUS_W-1:0] SW_MASK_FULL   = 16'h007F;
   localparam logic [STATUS_W-1:0] SW_MASK_QSTOP  = 16'h006F;
   localparam logic [STATUS_W-1:0] SW_MASK_SW_ON  = 16'h007B;
   localparam logic [STATUS_W-1:0] SW_OP_ENABLED  = 16'h0037;
   localparam logic [STATUS_W-1:0] SW_QUICK_STOP  = 16'h0007;
   localparam logic [STATUS_W-1:0] SW_NOT_READY   = 16'h0000;
   localparam logic [STATUS_W-1:0] SW_ON_DISABLED = 16'h0040;
   localparam logic [STATUS_W-1:0] SW_READY       = 16'h0031;
   localparam logic [STATUS_W-1:0] SW_SWITCHED_ON = 16'h0033;
   localparam logic [STATUS_W-1:0] SW_FAULT       = 16'h0008;
   localparam logic [STATUS_W-1:0] SW_FAULT_ACT   = 16'h000F;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_PWR_ON   = 6'b000010,
      PH_POWERED  = 6'b000100,
      PH_PWR_OFF  = 6'b001000,
      PH_SHUTDOWN = 6'b010000,
      PH_ERROR    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic                     op;
      logic                     power_on;
      logic [STATUS_W-1:0]      status_word;
      logic signed [DATA_W-1:0] actual_position;
      logic signed [DATA_W-1:0] command_position;
      logic signed [DATA_W-1:0] command_velocity;
   } req_item_type;

   typedef struct packed {
      logic [CW_W-1:0]          control_word;
      logic                     done_res;
      logic [ERR_W-1:0]         error_code;
      logic                     servo_enabled;
      logic signed [DATA_W-1:0] target_position;
      logic                     write_position;
      logic signed [DATA_W-1:0] target_velocity;
      logic                     write_velocity;
      logic [MODE_W-1:0]        mode_select;
      logic                     write_mode;
   } rsp_item_type;

   typedef struct packed {
      phase_type       phase;
      logic            last_power_request;
      logic            enabled_flag;
      logic [CW_W-1:0] held_control_word;
   } core_state_type;

   typedef struct packed {
      logic fieldbus_ready;
      logic op_mode;
   } cfg_type;

   function automatic logic [DATA_W-1:0] pos_keep(input logic [DATA_W-1:0] v);
      return v & POS_MASK;
   endfunction

   function automatic logic sw_is(input logic [STATUS_W-1:0] s,
                                  input logic [STATUS_W-1:0] mask,
                                  input logic [STATUS_W-1:0] value);
      return (s & mask) == value;
   endfunction

   function automatic logic drive_fault(input logic [STATUS_W-1:0] s);
      return sw_is(s, SW_MASK_STATE, SW_FAULT_ACT) || sw_is(s, SW_MASK_STATE, SW_FAULT);
   endfunction

endpackage

// ===== rtl/des_req_if.sv =====
// Input channel of the drive enable sequencer: valid, ready and one bus cycle's fields.
// Depends on des_pkg.
interface des_req_if import des_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic                     power_on;
   logic [STATUS_W-1:0]      status_word;
   logic signed [DATA_W-1:0] actual_position;
   logic signed [DATA_W-1:0] command_position;
   logic signed [DATA_W-1:0] command_velocity;

   modport source (output valid, op, power_on, status_word, actual_position,
                   command_position, command_velocity, input ready);
   modport sink (input valid, op, power_on, status_word, actual_position,
                 command_position, command_velocity, output ready);
endinterface

// ===== rtl/des_rsp_if.sv =====
// Result channel of the drive enable sequencer: valid, ready and the drive write fields.
// Depends on des_pkg.
interface des_rsp_if import des_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CW_W-1:0]          control_word;
   logic                     done_res;
   logic [ERR_W-1:0]         error_code;
   logic                     servo_enabled;
   logic signed [DATA_W-1:0] target_position;
   logic                     write_position;
   logic signed [DATA_W-1:0] target_velocity;
   logic                     write_velocity;
   logic [MODE_W-1:0]        mode_select;
   logic                     write_mode;

   modport source (output valid, control_word, done_res, error_code, servo_enabled,
                   target_position, write_position, target_velocity, write_velocity,
                   mode_select, write_mode, input ready);
   modport sink (input valid, control_word, done_res, error_code, servo_enabled,
                 target_position, write_position, target_velocity, write_velocity,
                 mode_select, write_mode, output ready);
endinterface

// ===== rtl/des_csr_if.sv =====
// Register write channel of the drive enable sequencer: valid, ready, index and data.
// Depends on des_pkg.
interface des_csr_if import des_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/des_in_stage.sv =====
// Input register of the drive enable sequencer: holds one accepted beat until the core takes it.
// Depends on des_pkg and des_req_if.
module des_in_stage import des_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   des_req_if.sink      req_chan,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         accept;

   assign req_chan.ready = !valid_ff || advance;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in = 1'b1;
         item_in.op               = req_chan.op;
         item_in.power_on         = req_chan.power_on;
         item_in.status_word      = req_chan.status_word;
         item_in.actual_position  = req_chan.actual_position;
         item_in.command_position = req_chan.command_position;
         item_in.command_velocity = req_chan.command_velocity;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/des_step.sv =====
// Step logic of the drive enable sequencer: decodes the status word, advances the enable
// phase and forms the result beat. Purely combinational; depends on des_pkg.
module des_step import des_pkg::*; (
   input  core_state_type cur,
   input  cfg_type        cfg,
   input  req_item_type   item,
   output core_state_type nxt,
   output rsp_item_type   result
);

   always_comb begin
      logic                update_req;
      logic                done;
      logic [ERR_W-1:0]    err;
      logic [DATA_W-1:0]   tpos;
      logic [DATA_W-1:0]   tvel;
      logic [MODE_W-1:0]   mode;
      logic                wpos;
      logic                wvel;
      logic                wmode;
      logic [STATUS_W-1:0] s;

      nxt        = cur;
      update_req = 1'b1;
      done       = 1'b0;
      err        = ERR_NONE;
      tpos       = '0;
      tvel       = '0;
      mode       = MODE_NONE;
      wpos       = 1'b0;
      wvel       = 1'b0;
      wmode      = 1'b0;
      s          = item.status_word;

      if (item.op == OP_POWER) begin
         if (item.power_on && !cur.last_power_request) begin
            if (!cfg.fieldbus_ready) begin
               err        = ERR_FIELDBUS;
               update_req = 1'b0;
            end else begin
               nxt.phase = PH_PWR_ON;
            end
         end else if (cur.last_power_request && !item.power_on) begin
            nxt.enabled_flag = 1'b0;
            nxt.phase        = PH_PWR_OFF;
         end else begin
            case (cur.phase)
               PH_PWR_ON: begin
                  if (sw_is(s, SW_MASK_FULL, SW_OP_ENABLED)) begin
                     done             = 1'b1;
                     nxt.enabled_flag = 1'b1;
                     nxt.phase        = PH_POWERED;
                  end else if (sw_is(s, SW_MASK_QSTOP, SW_QUICK_STOP)) begin
                     nxt.held_control_word = CW_DISABLE_VOLTAGE;
                  end else if (sw_is(s, SW_MASK_STATE, SW_NOT_READY)) begin
                     nxt.held_control_word = CW_FAULT_RESET;
                  end else if (sw_is(s, SW_MASK_STATE, SW_ON_DISABLED)) begin
                     nxt.held_control_word = CW_SHUTDOWN;
                  end else if (sw_is(s, SW_MASK_FULL, SW_READY)) begin
                     nxt.held_control_word = CW_SWITCH_ON;
                  end else if (sw_is(s, SW_MASK_SW_ON, SW_SWITCHED_ON)) begin
                     tpos                  = pos_keep(item.actual_position);
                     wpos                  = 1'b1;
                     mode                  = MODE_POSITION;
                     wmode                 = 1'b1;
                     nxt.held_control_word = CW_ENABLE_OP;
                  end else if (drive_fault(s)) begin
                     nxt.held_control_word = CW_FAULT_RESET;
                  end else begin
                     nxt.enabled_flag = 1'b0;
                     nxt.phase        = PH_ERROR;
                     err              = ERR_POWER_ON;
                  end
               end
               PH_POWERED: begin
                  if (drive_fault(s)) begin
                     nxt.enabled_flag = 1'b0;
                     nxt.phase        = PH_ERROR;
                     err              = ERR_POWERED_ON;
                  end else begin
                     done = 1'b1;
                  end
               end
               PH_PWR_OFF: begin
                  nxt.held_control_word = CW_SHUTDOWN;
                  nxt.phase             = PH_SHUTDOWN;
               end
               PH_SHUTDOWN: begin
                  nxt.held_control_word = CW_SHUTDOWN;
                  if (drive_fault(s)) begin
                     nxt.enabled_flag = 1'b0;
                     err              = ERR_POWER_OFF;
                  end else if (sw_is(s, SW_MASK_FULL, SW_READY)) begin
                     nxt.enabled_flag = 1'b0;
                     done             = 1'b1;
                     nxt.phase        = PH_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         if (update_req) begin
            nxt.last_power_request = item.power_on;
         end
      end else begin
         if (cur.phase == PH_ERROR) begin
            if (drive_fault(s)) begin
               nxt.held_control_word = CW_FAULT_RESET;
            end else if (sw_is(s, SW_MASK_STATE, SW_ON_DISABLED)) begin
               nxt.phase = PH_IDLE;
               done      = 1'b1;
            end
         end else begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
         end
      end

      if (cfg.fieldbus_ready && nxt.enabled_flag) begin
         if (cfg.op_mode == OPMODE_POSITION) begin
            tpos = pos_keep(item.command_position);
            wpos = 1'b1;
            mode = MODE_POSITION;
         end else begin
            tvel = item.command_velocity;
            wvel = 1'b1;
            mode = MODE_VELOCITY;
         end
         wmode = 1'b1;
      end

      result.control_word    = nxt.held_control_word;
      result.done_res        = done;
      result.error_code      = err;
      result.servo_enabled   = nxt.enabled_flag;
      result.target_position = $signed(tpos);
      result.write_position  = wpos;
      result.target_velocity = $signed(tvel);
      result.write_velocity  = wvel;
      result.mode_select     = mode;
      result.write_mode      = wmode;
   end

endmodule

// ===== rtl/des_core.sv =====
// Sequencer core: configuration registers, enable phase state and the step logic.
// Depends on des_pkg, des_csr_if and des_step.
module des_core import des_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   des_csr_if.sink      csr_chan,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   core_state_type state_ff;
   core_state_type state_in;
   core_state_type step_state;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FIELDBUS_READY: cfg_in.fieldbus_ready = csr_chan.wdata[0];
            CSR_OP_MODE:        cfg_in.op_mode        = csr_chan.wdata[0];
            default: begin
            end
         endcase
      end
   end

   des_step u_step (
      .cur    (state_ff),
      .cfg    (cfg_ff),
      .item   (item),
      .nxt    (step_state),
      .result (result)
   );

   assign state_in = advance ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                      <= '0;
         state_ff.phase              <= PH_IDLE;
         state_ff.last_power_request <= 1'b0;
         state_ff.enabled_flag       <= 1'b0;
         state_ff.held_control_word  <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/des_out_stage.sv =====
// Output register of the drive enable sequencer: holds a result beat until the receiver
// takes it. Depends on des_pkg and des_rsp_if.
module des_out_stage import des_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   des_rsp_if.source    rsp_chan,
   input  logic         load,
   input  rsp_item_type result,
   output logic         space
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;
   rsp_item_type data_in;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.control_word    = data_ff.control_word;
   assign rsp_chan.done_res        = data_ff.done_res;
   assign rsp_chan.error_code      = data_ff.error_code;
   assign rsp_chan.servo_enabled   = data_ff.servo_enabled;
   assign rsp_chan.target_position = data_ff.target_position;
   assign rsp_chan.write_position  = data_ff.write_position;
   assign rsp_chan.target_velocity = data_ff.target_velocity;
   assign rsp_chan.write_velocity  = data_ff.write_velocity;
   assign rsp_chan.mode_select     = data_ff.mode_select;
   assign rsp_chan.write_mode      = data_ff.write_mode;

endmodule

// ===== rtl/drive_enable_sequencer_top.sv =====
// Drive enable sequencer, top level.
// Each beat on req_chan is one fieldbus cycle: a power step or a reset-error step together
// with the drive status word, the actual position and the commanded position and velocity.
// Each accepted beat yields exactly one beat on rsp_chan with the control word, done flag,
// error code and the position, velocity and mode writes for that cycle.
// csr_chan writes fieldbus_ready (index 0) and op_mode (index 1); it is always ready. The user
// must write it only while no beat is in flight; the block itself does not enforce this.
// A beat accepted on req_chan is registered in the input register, stepped through the decode
// logic into the output register and taken from there by the receiver. Throughput is one beat
// per cycle while rsp_chan is not stalled; the input register and the output register each
// hold one beat, so a new beat is accepted while a finished result waits.
// When the receiver stalls, the output register holds its beat, the input register fills,
// and req_chan.ready drops until rsp_chan moves again.
// Reset is synchronous: both registers empty, the phase returns to idle, the held control
// word, the power request and the enable flag clear, and both registers of csr_chan clear.
// Depends on des_pkg, the channel interfaces, assert_macros.svh, des_in_stage, des_core and des_out_stage.
`include "assert_macros.svh"

module drive_enable_sequencer_top import des_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   des_req_if.sink   req_chan,
   des_rsp_if.source rsp_chan,
   des_csr_if.sink   csr_chan
);

   logic         in_valid;
   logic         out_space;
   logic         advance;
   req_item_type item;
   rsp_item_type result;

   assign advance = in_valid && out_space;

   des_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .item_valid (in_valid),
      .item       (item)
   );

   des_core u_core (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .advance  (advance),
      .item     (item),
      .result   (result)
   );

   des_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_chan (rsp_chan),
      .load     (advance),
      .result   (result),
      .space    (out_space)
   );

   `ASSERT_IMPLIES(a_full_blocks_input, in_valid && rsp_chan.valid && !rsp_chan.ready,
      !req_chan.ready, "input accepted while both stages are full")
   `ASSERT_IMPLIES(a_velocity_mode, rsp_chan.valid && rsp_chan.write_velocity,
      rsp_chan.write_mode && rsp_chan.mode_select == MODE_VELOCITY,
      "velocity write without velocity mode")
   `ASSERT_IMPLIES(a_done_no_error, rsp_chan.valid && rsp_chan.done_res,
      rsp_chan.error_code == ERR_NONE, "done flagged together with an error")
   `ASSERT_IMPLIES(a_no_bus_no_write, rsp_chan.valid && rsp_chan.error_code == ERR_FIELDBUS,
      !rsp_chan.write_mode && !rsp_chan.write_position, "drive write while fieldbus not ready")

endmodule

// ===== verif/drive_enable_sequencer_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for drive_enable_sequencer_top: directed and random fieldbus cycles
// are checked against a built-in model of the enable sequence and the cyclic writes.
// Depends on des_pkg, des_req_if, des_rsp_if, des_csr_if and the RTL of the block.
module drive_enable_sequencer_top_tb;
   import des_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   des_req_if req_chan();
   des_rsp_if rsp_chan();
   des_csr_if csr_chan();

   drive_enable_sequencer_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #1 clock = ~clock;

   // Model of the sequencer state and its register settings.
   phase_type       drv_phase      = PH_IDLE;
   logic            power_req_seen = 1'b0;
   logic            servo_on       = 1'b0;
   logic [CW_W-1:0] held_cw        = '0;
   logic            bus_ready      = 1'b0;
   logic            velocity_mode  = 1'b0;

   rsp_item_type expected_drive_writes[$];
   int           failures      = 0;
   int           burst_left    = 0;
   bit           gaps_on       = 1'b1;
   int           hold_request  = 0;
   logic         power_level   = 1'b0;

   function automatic logic in_fault(input logic [STATUS_W-1:0] s);
      return ((s & SW_MASK_STATE) == SW_FAULT_ACT) || ((s & SW_MASK_STATE) == SW_FAULT);
   endfunction

   function automatic rsp_item_type next_drive_writes(input req_item_type it);
      rsp_item_type    r;
      logic            keep_req;
      logic [STATUS_W-1:0] s;
      r = '0;
      s = it.status_word;
      if (it.op == OP_POWER) begin
         keep_req = 1'b1;
         if (it.power_on && !power_req_seen) begin
            if (!bus_ready) begin
               r.error_code = ERR_FIELDBUS;
               keep_req = 1'b0;
            end else begin
               drv_phase = PH_PWR_ON;
            end
         end else if (power_req_seen && !it.power_on) begin
            servo_on = 1'b0;
            drv_phase = PH_PWR_OFF;
         end else begin
            case (drv_phase)
               PH_PWR_ON: begin
                  if ((s & SW_MASK_FULL) == SW_OP_ENABLED) begin
                     r.done_res = 1'b1;
                     servo_on = 1'b1;
                     drv_phase = PH_POWERED;
                  end else if ((s & SW_MASK_QSTOP) == SW_QUICK_STOP) begin
                     held_cw = CW_DISABLE_VOLTAGE;
                  end else if ((s & SW_MASK_STATE) == SW_NOT_READY) begin
                     held_cw = CW_FAULT_RESET;
                  end else if ((s & SW_MASK_STATE) == SW_ON_DISABLED) begin
                     held_cw = CW_SHUTDOWN;
                  end else if ((s & SW_MASK_FULL) == SW_READY) begin
                     held_cw = CW_SWITCH_ON;
                  end else if ((s & SW_MASK_SW_ON) == SW_SWITCHED_ON) begin
                     r.target_position = it.actual_position & POS_MASK;
                     r.write_position = 1'b1;
                     r.mode_select = MODE_POSITION;
                     r.write_mode = 1'b1;
                     held_cw = CW_ENABLE_OP;
                  end else if (in_fault(s)) begin
                     held_cw = CW_FAULT_RESET;
                  end else begin
                     servo_on = 1'b0;
                     drv_phase = PH_ERROR;
                     r.error_code = ERR_POWER_ON;
                  end
               end
               PH_POWERED: begin
                  if (in_fault(s)) begin
                     servo_on = 1'b0;
                     drv_phase = PH_ERROR;
                     r.error_code = ERR_POWERED_ON;
                  end else begin
                     r.done_res = 1'b1;
                  end
               end
               PH_PWR_OFF: begin
                  held_cw = CW_SHUTDOWN;
                  drv_phase = PH_SHUTDOWN;
               end
               PH_SHUTDOWN: begin
                  held_cw = CW_SHUTDOWN;
                  if (in_fault(s)) begin
                     servo_on = 1'b0;
                     r.error_code = ERR_POWER_OFF;
                  end else if ((s & SW_MASK_FULL) == SW_READY) begin
                     servo_on = 1'b0;
                     r.done_res = 1'b1;
                     drv_phase = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         if (keep_req)
            power_req_seen = it.power_on;
      end else if (drv_phase == PH_ERROR) begin
         if (in_fault(s)) begin
            held_cw = CW_FAULT_RESET;
         end else if ((s & SW_MASK_STATE) == SW_ON_DISABLED) begin
            drv_phase = PH_IDLE;
            r.done_res = 1'b1;
         end
      end else begin
         drv_phase = PH_IDLE;
         r.done_res = 1'b1;
      end

      if (bus_ready && servo_on) begin
         if (velocity_mode == OPMODE_POSITION) begin
            r.target_position = it.command_position & POS_MASK;
            r.write_position = 1'b1;
            r.mode_select = MODE_POSITION;
         end else begin
            r.target_velocity = it.command_velocity;
            r.write_velocity = 1'b1;
            r.mode_select = MODE_VELOCITY;
         end
         r.write_mode = 1'b1;
      end
      r.control_word = held_cw;
      r.servo_enabled = servo_on;
      return r;
   endfunction

   function automatic req_item_type next_random_beat();
      req_item_type it;
      logic [STATUS_W-1:0] base;
      if ($urandom_range(0, 99) < 5)
         power_level = ~power_level;
      it.op = (drv_phase == PH_ERROR) ? ($urandom_range(0, 9) < 4) : ($urandom_range(0, 99) < 5);
      it.power_on = power_level;
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 14, 15: base = SW_OP_ENABLED;
         4:       base = SW_SWITCHED_ON;
         5:       base = SW_READY;
         6, 7:    base = SW_ON_DISABLED;
         8:       base = SW_NOT_READY;
         9:       base = SW_QUICK_STOP;
         10:      base = SW_FAULT_ACT;
         11:      base = SW_FAULT;
         default: base = STATUS_W'($urandom);
      endcase
      it.status_word = base | (STATUS_W'($urandom) & 16'hFF80);
      it.actual_position = $urandom;
      it.command_position = $urandom;
      it.command_velocity = $urandom;
      return it;
   endfunction

   task automatic send_beat(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(0, 6) : 0;
         burst_left = $urandom_range(1, 12);
         if (gap != 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.op <= it.op;
      req_chan.power_on <= it.power_on;
      req_chan.status_word <= it.status_word;
      req_chan.actual_position <= it.actual_position;
      req_chan.command_position <= it.command_position;
      req_chan.command_velocity <= it.command_velocity;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_drive_writes.push_back(next_drive_writes(it));
   endtask

   task automatic send_cmd(input logic op, input logic pon, input logic [STATUS_W-1:0] sw,
                           input logic [DATA_W-1:0] act, input logic [DATA_W-1:0] cpos,
                           input logic [DATA_W-1:0] cvel);
      req_item_type it;
      it.op = op;
      it.power_on = pon;
      it.status_word = sw;
      it.actual_position = act;
      it.command_position = cpos;
      it.command_velocity = cvel;
      send_beat(it);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_beat(next_random_beat());
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (expected_drive_writes.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.wdata <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      if (idx == CSR_FIELDBUS_READY)
         bus_ready = val;
      else
         velocity_mode = val;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_drive_writes.size() == 0) begin
            $error("result beat arrived with no expected result pending");
            failures++;
         end else begin
            want = expected_drive_writes.pop_front();
            check_field("control_word", 32'(want.control_word), 32'(rsp_chan.control_word));
            check_field("done_res", 32'(want.done_res), 32'(rsp_chan.done_res));
            check_field("error_code", 32'(want.error_code), 32'(rsp_chan.error_code));
            check_field("servo_enabled", 32'(want.servo_enabled),
                        32'(rsp_chan.servo_enabled));
            check_field("target_position", want.target_position, rsp_chan.target_position);
            check_field("write_position", 32'(want.write_position),
                        32'(rsp_chan.write_position));
            check_field("target_velocity", want.target_velocity, rsp_chan.target_velocity);
            check_field("write_velocity", 32'(want.write_velocity),
                        32'(rsp_chan.write_velocity));
            check_field("mode_select", 32'(want.mode_select), 32'(rsp_chan.mode_select));
            check_field("write_mode", 32'(want.write_mode), 32'(rsp_chan.write_mode));
         end
      end
   end

   // The receiver switches among four stall patterns and honors long hold requests.
   initial begin : result_sink
      int cyc;
      int hold_cnt;
      int pattern;
      cyc = 0;
      hold_cnt = 0;
      pattern = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_request != 0) begin
            hold_cnt = hold_request;
            hold_request = 0;
         end
         if (cyc % 64 == 0)
            pattern = $urandom_range(0, 3);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else begin
            case (pattern)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 9) < 3);
               default: rsp_chan.ready <= (cyc % 8 >= 3);
            endcase
         end
      end
   end

   task automatic test_no_fieldbus();
      write_csr(CSR_FIELDBUS_READY, 1'b0);
      write_csr(CSR_OP_MODE, OPMODE_POSITION);
      send_cmd(OP_POWER, 1'b1, SW_ON_DISABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_RESET_ERR, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_cmd(OP_POWER, 1'b0, 16'h0000, 32'h0, 32'h0, 32'h0);
      wait_all_results();
   endtask

   task automatic test_power_sequence();
      write_csr(CSR_FIELDBUS_READY, 1'b1);
      send_cmd(OP_POWER, 1'b1, 16'hFFFF, 32'h1, 32'h2, 32'h3);
      send_cmd(OP_POWER, 1'b1, SW_NOT_READY, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_ON_DISABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_READY, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_QUICK_STOP, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_FAULT_ACT, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_SWITCHED_ON, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_OP_ENABLED, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_cmd(OP_POWER, 1'b1, 16'hFFB7, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_cmd(OP_POWER, 1'b1, SW_FAULT, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send_cmd(OP_RESET_ERR, 1'b1, SW_FAULT_ACT, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_RESET_ERR, 1'b1, SW_ON_DISABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_OP_ENABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b0, SW_OP_ENABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b0, SW_OP_ENABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b0, SW_FAULT_ACT, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b0, SW_READY, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, SW_READY, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b1, 16'h0001, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_RESET_ERR, 1'b1, SW_ON_DISABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_POWER, 1'b0, SW_ON_DISABLED, 32'h0, 32'h0, 32'h0);
      send_cmd(OP_RESET_ERR, 1'b0, SW_OP_ENABLED, 32'h0, 32'h0, 32'h0);
      wait_all_results();
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 6; k++) begin
         wait_all_results();
         write_csr(CSR_FIELDBUS_READY, (k % 3) != 2);
         write_csr(CSR_OP_MODE, 1'(k % 2));
         gaps_on = ($urandom_range(0, 2) != 0);
         send_random(310);
      end
      wait_all_results();
      gaps_on = 1'b1;
   endtask

   task automatic test_output_stall();
      write_csr(CSR_FIELDBUS_READY, 1'b1);
      write_csr(CSR_OP_MODE, 1'b1);
      gaps_on = 1'b0;
      hold_request = 300;
      send_random(40);
      wait_all_results();
      gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      write_csr(CSR_OP_MODE, OPMODE_POSITION);
      repeat (3) begin
         send_random(10);
         wait_all_results();
      end
   endtask

   initial begin : timeout
      #800000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = OP_POWER;
      req_chan.power_on = 1'b0;
      req_chan.status_word = '0;
      req_chan.actual_position = '0;
      req_chan.command_position = '0;
      req_chan.command_velocity = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_FIELDBUS_READY;
      csr_chan.wdata = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_no_fieldbus();
      test_power_sequence();
      test_random_settings();
      test_output_stall();
      test_sender_pause();

      wait_all_results();
      repeat (10) @(posedge clock);
      if (expected_drive_writes.size() != 0) begin
         $error("%0d expected results never arrived", expected_drive_writes.size());
         failures++;
      end
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
